// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge while reset is released.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset or not.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/hrt_pkg.sv
// ----------------------------------------------------------------------------
// Heap range tracker package
// Shared types and constants for the heap range tracker.
// ----------------------------------------------------------------------------
package hrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] address;
        logic [63:0] alloc_size;
        logic [63:0] loaded_value;
        logic [63:0] instr_ptr;
    } t_in;

    typedef struct packed {
        logic        reported;
        logic [63:0] access_base;
        logic [63:0] access_offset;
        logic [63:0] pointee_base;
        logic [63:0] pointee_offset;
        logic [63:0] record_ip;
        logic        table_full;
    } t_out;

    // One table entry as stored in memory.
    typedef struct packed {
        logic        valid;
        logic [63:0] base;
        logic [63:0] size;
    } t_entry;

endpackage

// File: rtl/hrt_table_mem.sv
// ----------------------------------------------------------------------------
// Range table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hrt_table_mem #(
    parameter int DEPTH  = hrt_pkg::TABLE_ENTRIES_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  hrt_pkg::t_entry     i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output hrt_pkg::t_entry     o_rdata
);

    hrt_pkg::t_entry r_mem [DEPTH];
    hrt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hrt_match.sv
// ----------------------------------------------------------------------------
// Range match stage
// Tests one key against one entry and registers hit, base and offset.
// ----------------------------------------------------------------------------
module hrt_match (
    input  logic            i_clk,
    input  logic [63:0]     i_key,
    input  hrt_pkg::t_entry i_ent,
    output logic            o_hit,
    output logic [63:0]     o_base,
    output logic [63:0]     o_off
);

    logic [64:0] w_diff;
    logic        r_hit;
    logic [63:0] r_base;
    logic [63:0] r_off;

    // A borrow out of the 65-bit difference means the key lies below the base.
    assign w_diff = {1'b0, i_key} - {1'b0, i_ent.base};

    always_ff @(posedge i_clk) begin
        r_hit  <= i_ent.valid && !w_diff[64] && (w_diff[63:0] <= i_ent.size);
        r_base <= i_ent.base;
        r_off  <= w_diff[63:0];
    end

    assign o_hit  = r_hit;
    assign o_base = r_base;
    assign o_off  = r_off;

endmodule

// File: rtl/heap_range_tracker_core.sv
// ----------------------------------------------------------------------------
// Heap range tracker core
// An input beat is taken only while idle; the controller then scans the whole
// table through the single read port of the range memory, drains the match
// stage and writes back, and the next beat is taken once the result is loaded
// into the output register. Reset: a clearing pass invalidates every entry; no
// input beat is taken until it ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heap_range_tracker_core #(
    parameter int TABLE_ENTRIES = hrt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hrt_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output hrt_pkg::t_out o_out_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    // Controller states. CLEAR sweeps the memory after reset, SCAN issues one
    // read per cycle, DRAIN lets the last reads pass the match stage, and DONE
    // does the write-back and loads the output register.
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    hrt_pkg::t_in     r_item;

    // Read pipeline tags: p1 marks the registered memory data, p2 the
    // registered match results.
    logic             r_p1_vld;
    logic [IDX_W-1:0] r_p1_idx;
    logic             r_p2_vld;
    logic [IDX_W-1:0] r_p2_idx;
    logic             r_p2_free;

    // First hit found so far for the address (a), the loaded value (b), and
    // the first free slot.
    logic             r_found_a, r_found_b, r_found_free;
    logic [IDX_W-1:0] r_idx_a, r_idx_free;
    logic [63:0]      r_base_a, r_off_a, r_base_b, r_off_b;

    logic             r_out_vld;
    hrt_pkg::t_out    r_out;
    hrt_pkg::t_out    w_res;

    logic             w_accept;
    logic             w_load;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    hrt_pkg::t_entry  w_wdata;
    logic             w_re;
    hrt_pkg::t_entry  w_rdata;

    logic             w_hit_a, w_hit_b;
    logic [63:0]      w_mbase_a, w_moff_a, w_mbase_b, w_moff_b;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    // The result moves to the output register once that register is free or
    // being emptied in the same cycle.
    assign w_load      = (r_state == S_DONE) && (!r_out_vld || !i_out_stall);
    assign w_re        = (r_state == S_SCAN);

    hrt_table_mem #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // Both lookups of a pointer read share the same pass over the table.
    hrt_match u_match_a (
        .i_clk  (i_clk),
        .i_key  (r_item.address),
        .i_ent  (w_rdata),
        .o_hit  (w_hit_a),
        .o_base (w_mbase_a),
        .o_off  (w_moff_a)
    );

    hrt_match u_match_b (
        .i_clk  (i_clk),
        .i_key  (r_item.loaded_value),
        .i_ent  (w_rdata),
        .o_hit  (w_hit_b),
        .o_base (w_mbase_b),
        .o_off  (w_moff_b)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_vld && !r_p2_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= w_re;
            r_p2_vld <= r_p1_vld;
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Index tags travel with the data; they need no reset.
    always_ff @(posedge i_clk) begin
        r_p1_idx  <= r_idx;
        r_p2_idx  <= r_p1_idx;
        r_p2_free <= !w_rdata.valid;
        if (w_accept) begin
            r_item <= i_in_data;
        end
    end

    // Keep only the lowest-numbered hit of each kind; entries arrive in
    // ascending order, so the first one seen wins.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found_a    <= 1'b0;
            r_found_b    <= 1'b0;
            r_found_free <= 1'b0;
        end else if (w_accept) begin
            r_found_a    <= 1'b0;
            r_found_b    <= 1'b0;
            r_found_free <= 1'b0;
        end else if (r_p2_vld) begin
            if (w_hit_a && !r_found_a) begin
                r_found_a <= 1'b1;
            end
            if (w_hit_b && !r_found_b) begin
                r_found_b <= 1'b1;
            end
            if (r_p2_free && !r_found_free) begin
                r_found_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            if (w_hit_a && !r_found_a) begin
                r_idx_a  <= r_p2_idx;
                r_base_a <= w_mbase_a;
                r_off_a  <= w_moff_a;
            end
            if (w_hit_b && !r_found_b) begin
                r_base_b <= w_mbase_b;
                r_off_b  <= w_moff_b;
            end
            if (r_p2_free && !r_found_free) begin
                r_idx_free <= r_p2_idx;
            end
        end
    end

    // Memory write port: the clearing sweep, a new range, or an invalidation.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
        end else if (w_load) begin
            case (r_item.op)
                hrt_pkg::OP_ALLOC: begin
                    w_we          = r_found_free;
                    w_waddr       = r_idx_free;
                    w_wdata.valid = 1'b1;
                    w_wdata.base  = r_item.address;
                    w_wdata.size  = r_item.alloc_size;
                end
                hrt_pkg::OP_FREE: begin
                    w_we    = r_found_a;
                    w_waddr = r_idx_a;
                end
                default: begin
                    w_we = 1'b0;
                end
            endcase
        end
    end

    // Result assembly; fields with no record stay zero.
    always_comb begin
        w_res = '0;
        case (r_item.op)
            hrt_pkg::OP_ALLOC: begin
                w_res.table_full = !r_found_free;
            end
            hrt_pkg::OP_READ: begin
                if (r_found_a && r_found_b) begin
                    w_res.reported       = 1'b1;
                    w_res.access_base    = r_base_a;
                    w_res.access_offset  = r_off_a;
                    w_res.pointee_base   = r_base_b;
                    w_res.pointee_offset = r_off_b;
                    w_res.record_ip      = r_item.instr_ptr;
                end
            end
            hrt_pkg::OP_WRITE: begin
                if (r_found_a) begin
                    w_res.reported      = 1'b1;
                    w_res.access_base   = r_base_a;
                    w_res.access_offset = r_off_a;
                    w_res.record_ip     = r_item.instr_ptr;
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    // Output register: holds the beat while the far side stalls, and lets the
    // controller take the next input beat meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // The scan pipeline is empty whenever a new beat may be taken.
    `ASSERT_SYNC(a_idle_pipe_empty, i_clk, i_rst_n, (r_state == S_IDLE) |-> (!r_p1_vld && !r_p2_vld), "scan pipeline busy while idle")
    // The memory is only written by the clearing sweep or at write-back.
    `ASSERT_SYNC(a_write_window, i_clk, i_rst_n, w_we |-> (r_state == S_CLEAR || r_state == S_DONE), "memory write outside clear or write-back")
    // A new output beat only comes out of the write-back state.
    `ASSERT_SYNC(a_out_from_done, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_DONE), "output loaded outside write-back")
    // A dropped allocation never carries an access record.
    `ASSERT_SYNC(a_full_no_record, i_clk, i_rst_n, r_out_vld |-> !(r_out.table_full && r_out.reported), "table full and record together")

endmodule
